### design/tclc_pkg.sv
// Shared types, constants and curve table function for the two-channel lux calculator.
package tclc_pkg;

  localparam int CURVE_ENTRIES_DEF = 33;
  localparam int CNT_W = 20;
  localparam int DEN_W = 37;
  localparam int NUM_W = 62;
  localparam int LUX_W = 32;

  localparam logic CFG_HIGH_GAIN = 1'b0;
  localparam logic CFG_INTEG_MS = 1'b1;

  localparam logic [15:0] INTEG_RESET = 16'd402;
  localparam logic [27:0] POW_BASE = 28'd199229440;
  localparam logic [12:0] POW_SLOPE = 13'd6200;
  localparam logic [8:0] NORM_MS = 9'd402;
  localparam logic [28:0] LIN_FACTOR = 29'd1646592;
  localparam logic [20:0] POW_DEN = 21'd1600000;
  localparam logic [20:0] LIN_DEN = 21'd100000;

  typedef enum logic [1:0] {
    PC_POW,
    PC_MID,
    PC_HI,
    PC_TOP
  } piece_t;

  typedef struct packed {
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] c1;
    piece_t pc;
    logic oor;
  } cls_t;

  function automatic logic [63:0] q30_pow(input logic [63:0] a, input int n);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int k = 0; k < n; k++) begin
      r = (r * a) >> 30;
    end
    return r;
  endfunction

  function automatic logic [15:0] curve_entry(input int i, input int n);
    logic [63:0] x;
    logic [63:0] x7;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    x = (64'(i) << 29) / 64'(n - 1);
    x7 = q30_pow(x, 7);
    lo = 64'd0;
    hi = 64'd65535;
    for (int k = 0; k < 20; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (q30_pow(mid << 14, 5) <= x7) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo[15:0];
  endfunction

endpackage

### design/tclc_ifs.sv
// Valid/ready channel interfaces for count samples and lux results.
interface tclc_sample_if;
  logic valid;
  logic ready;
  logic [15:0] broadband_count;
  logic [15:0] infrared_count;
  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink (input valid, input broadband_count, input infrared_count, output ready);
endinterface

interface tclc_result_if;
  logic valid;
  logic ready;
  logic [31:0] lux_value;
  logic saturated;
  logic out_of_range;
  modport source (output valid, output lux_value, output saturated, output out_of_range,
                  input ready);
  modport sink (input valid, input lux_value, input saturated, input out_of_range,
                output ready);
endinterface

### design/tclc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and side data.
module tclc_div #(
  parameter int NW = 62,
  parameter int DW = 37,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);
  localparam int TW = (NW - QW > DW) ? NW - QW : DW;

  logic [TW-1:0] top_ext;
  logic [TW-1:0] den_ext;
  logic ovf0;
  logic [DW-1:0] rem0;

  assign top_ext = TW'(num[NW-1:QW]);
  assign den_ext = TW'(den);
  assign ovf0 = top_ext >= den_ext;
  assign rem0 = ovf0 ? '0 : top_ext[DW-1:0];

  logic [DW-1:0] r_rem [QW];
  logic [DW-1:0] r_den [QW];
  logic [QW-1:0] r_low [QW];
  logic [QW-1:0] r_quo [QW];
  logic [SW-1:0] r_side [QW];
  logic r_ovf [QW];
  logic r_vld [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] p_rem;
    logic [DW-1:0] p_den;
    logic [QW-1:0] p_low;
    logic [QW-1:0] p_quo;
    logic [SW-1:0] p_side;
    logic p_ovf;
    logic p_vld;
    logic [DW:0] sh;
    logic [DW:0] diff;
    logic take;

    if (k == 0) begin : g_first
      assign p_rem = rem0;
      assign p_den = den;
      assign p_low = num[QW-1:0];
      assign p_quo = '0;
      assign p_side = side_in;
      assign p_ovf = ovf0;
      assign p_vld = in_vld;
    end else begin : g_next
      assign p_rem = r_rem[k-1];
      assign p_den = r_den[k-1];
      assign p_low = r_low[k-1];
      assign p_quo = r_quo[k-1];
      assign p_side = r_side[k-1];
      assign p_ovf = r_ovf[k-1];
      assign p_vld = r_vld[k-1];
    end

    assign sh = {p_rem, p_low[QW-1-k]};
    assign diff = sh - {1'b0, p_den};
    assign take = ~diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        r_vld[k] <= 1'b0;
      end else if (en) begin
        r_vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_rem[k] <= take ? diff[DW-1:0] : sh[DW-1:0];
        r_den[k] <= p_den;
        r_low[k] <= p_low;
        r_quo[k] <= p_quo | (QW'(take) << (QW - 1 - k));
        r_side[k] <= p_side;
        r_ovf[k] <= p_ovf;
      end
    end
  end

  assign out_vld = r_vld[QW-1];
  assign quo = r_quo[QW-1];
  assign ovf = r_ovf[QW-1];
  assign side_out = r_side[QW-1];
endmodule

### design/two_channel_lux_calculator.sv
// Top level: two-channel lux calculator pipeline with configuration registers.
//
//  channel   dir  payload
//  samples   in   broadband_count[15:0], infrared_count[15:0]
//  results   out  lux_value[31:0], saturated, out_of_range
//  cfg       in   cfg_we, cfg_index[0], cfg_data[15:0]
//
// One item per cycle while the result is not stalled; the stages are s0, s1, the bit-per-stage
// curve ratio divider, s2 to s5, the bit-per-stage normalization divider and the output register.
// Reset clears valid bits and config to high_gain 0, integration_ms 402.
// A stalled result holds every stage; the input is ready whenever the output
// register is empty or being taken.
module two_channel_lux_calculator #(
  parameter int CURVE_ENTRIES = tclc_pkg::CURVE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  tclc_sample_if.sink samples,
  tclc_result_if.source results
);
  import tclc_pkg::*;

  localparam int SPAN = CURVE_ENTRIES - 1;
  localparam int IDX_W = $clog2(2 * SPAN + 1);
  localparam int PQW = IDX_W + 16;
  localparam int PNW = CNT_W + IDX_W + 16;
  localparam int IW = $clog2(CURVE_ENTRIES);

  logic high_gain;
  logic [15:0] integration_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_gain <= 1'b0;
      integration_ms <= INTEG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_GAIN: high_gain <= cfg_data[0];
        CFG_INTEG_MS: integration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] curve [CURVE_ENTRIES];
  for (genvar i = 0; i < CURVE_ENTRIES; i++) begin : g_curve
    assign curve[i] = curve_entry(i, CURVE_ENTRIES);
  end

  logic en;
  logic o_vld;
  assign en = !o_vld || results.ready;
  assign samples.ready = en;

  // stage 0: gain shift
  logic s0_vld;
  logic [CNT_W-1:0] s0_c0, s0_c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= samples.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_c0 <= high_gain ? {4'b0, samples.broadband_count} : {samples.broadband_count, 4'b0};
      s0_c1 <= high_gain ? {4'b0, samples.infrared_count} : {samples.infrared_count, 4'b0};
    end
  end

  // stage 1: piece select
  logic [23:0] c1x10, c0x13;
  logic [26:0] c1x100, c0x61;
  logic [22:0] c1x5, c0x4;
  piece_t pc_next;
  logic oor_next;
  assign c1x10 = 24'(s0_c1) * 24'd10;
  assign c0x13 = 24'(s0_c0) * 24'd13;
  assign c1x100 = 27'(s0_c1) * 27'd100;
  assign c0x61 = 27'(s0_c0) * 27'd61;
  assign c1x5 = 23'(s0_c1) * 23'd5;
  assign c0x4 = 23'(s0_c0) << 2;
  assign oor_next = (s0_c0 == '0) || (c1x10 > c0x13);

  always_comb begin
    if ({s0_c1, 1'b0} <= {1'b0, s0_c0}) begin
      pc_next = PC_POW;
    end else if (c1x100 <= c0x61) begin
      pc_next = PC_MID;
    end else if (c1x5 <= c0x4) begin
      pc_next = PC_HI;
    end else begin
      pc_next = PC_TOP;
    end
  end

  logic s1_vld;
  cls_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s0_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1.c0 <= s0_c0;
      s1.c1 <= s0_c1;
      s1.pc <= pc_next;
      s1.oor <= oor_next;
    end
  end

  // ratio divider
  logic [PNW-1:0] p_num;
  assign p_num = (PNW'(s1.c1) * PNW'(2 * SPAN)) << 16;

  logic d1_vld;
  logic [PQW-1:0] d1_p;
  logic d1_ovf;
  cls_t d1;

  tclc_div #(.NW(PNW), .DW(CNT_W), .QW(PQW), .SW($bits(cls_t))) u_ratio_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(s1_vld),
    .num(p_num), .den(s1.c0), .side_in(s1),
    .out_vld(d1_vld), .quo(d1_p), .ovf(d1_ovf), .side_out(d1)
  );

  // stage 2: curve interpolation
  logic [IDX_W-1:0] idx;
  logic [15:0] frac, ta, tb, tdiff;
  logic [31:0] tprod;
  logic [15:0] f_next;
  assign idx = d1_p[PQW-1:16];
  assign frac = d1_p[15:0];

  always_comb begin
    ta = curve[idx[IW-1:0]];
    tb = curve[IW'(idx[IW-1:0] + IW'(1))];
    tdiff = (tb > ta) ? tb - ta : 16'd0;
    tprod = 32'(tdiff) * 32'(frac);
    if (d1_ovf || (IDX_W'(idx) >= IDX_W'(SPAN))) begin
      f_next = curve[CURVE_ENTRIES-1];
    end else begin
      f_next = ta + tprod[31:16];
    end
  end

  logic s2_vld;
  cls_t s2;
  logic [15:0] s2_f;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= d1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= d1;
      s2_f <= f_next;
    end
  end

  // stage 3: piece terms
  logic [28:0] pow_sub;
  logic [31:0] ka_c0, kb_c1;
  logic [31:0] diff_next;
  logic [28:0] fac_next;
  logic [15:0] t_eff;
  logic [DEN_W-1:0] den_next;
  assign pow_sub = 29'(s2_f) * 29'(POW_SLOPE);
  assign t_eff = (integration_ms == '0) ? 16'd1 : integration_ms;

  always_comb begin
    case (s2.pc)
      PC_MID: begin
        ka_c0 = 32'(s2.c0) * 32'd2240;
        kb_c1 = 32'(s2.c1) * 32'd3100;
      end
      PC_HI: begin
        ka_c0 = 32'(s2.c0) * 32'd1280;
        kb_c1 = 32'(s2.c1) * 32'd1530;
      end
      default: begin
        ka_c0 = 32'(s2.c0) * 32'd146;
        kb_c1 = 32'(s2.c1) * 32'd112;
      end
    endcase
    if (s2.pc == PC_POW) begin
      diff_next = (29'(POW_BASE) > pow_sub) ? 32'(29'(POW_BASE) - pow_sub) : 32'd0;
      fac_next = 29'(s2.c0) * 29'(NORM_MS);
      den_next = DEN_W'(t_eff) * DEN_W'(POW_DEN);
    end else begin
      diff_next = (ka_c0 > kb_c1) ? ka_c0 - kb_c1 : 32'd0;
      fac_next = LIN_FACTOR;
      den_next = DEN_W'(t_eff) * DEN_W'(LIN_DEN);
    end
  end

  logic s3_vld, s3_oor;
  logic [31:0] s3_diff;
  logic [28:0] s3_fac;
  logic [DEN_W-1:0] s3_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_oor <= s2.oor;
      s3_diff <= diff_next;
      s3_fac <= fac_next;
      s3_den <= den_next;
    end
  end

  // stage 4: numerator product
  logic s4_vld, s4_oor;
  logic [60:0] s4_num;
  logic [DEN_W-1:0] s4_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_oor <= s3_oor;
      s4_num <= 61'(s3_fac) * 61'(s3_diff);
      s4_den <= s3_den;
    end
  end

  // stage 5: rounding offset
  logic s5_vld, s5_oor;
  logic [NUM_W-1:0] s5_num;
  logic [DEN_W-1:0] s5_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_oor <= s4_oor;
      s5_num <= NUM_W'(s4_num) + NUM_W'(s4_den >> 1);
      s5_den <= s4_den;
    end
  end

  // normalization divider
  logic d2_vld, d2_ovf, d2_oor;
  logic [LUX_W-1:0] d2_q;

  tclc_div #(.NW(NUM_W), .DW(DEN_W), .QW(LUX_W), .SW(1)) u_lux_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(s5_vld),
    .num(s5_num), .den(s5_den), .side_in(s5_oor),
    .out_vld(d2_vld), .quo(d2_q), .ovf(d2_ovf), .side_out(d2_oor)
  );

  // output register
  logic [LUX_W-1:0] o_lux;
  logic o_sat, o_oor;
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= d2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_lux <= d2_oor ? '0 : (d2_ovf ? '1 : d2_q);
      o_sat <= !d2_oor && d2_ovf;
      o_oor <= d2_oor;
    end
  end

  assign results.valid = o_vld;
  assign results.lux_value = o_lux;
  assign results.saturated = o_sat;
  assign results.out_of_range = o_oor;
endmodule

### sim/tclc_lux_checker.sv
// Checker for the lux calculator: predicts lux from sampled counts and compares results.
module tclc_lux_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  tclc_sample_if samples,
  tclc_result_if results,
  output int fail_count,
  output int outstanding
);
  import tclc_pkg::*;

  typedef struct {
    logic [31:0] lux;
    logic sat;
    logic oor;
  } lux_res_t;

  localparam int SPAN = CURVE_ENTRIES_DEF - 1;

  logic [15:0] curve [CURVE_ENTRIES_DEF];
  lux_res_t expected_lux [$];
  logic gain_high;
  logic [15:0] integ_ms;

  function automatic longint unsigned pow_q30(input longint unsigned a, input int n);
    longint unsigned r;
    r = 64'd1 << 30;
    for (int k = 0; k < n; k++) r = (r * a) >> 30;
    return r;
  endfunction

  function automatic longint unsigned sub_floor(input longint unsigned a, b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic lux_res_t lux_predict(input logic [15:0] bb, ir);
    longint unsigned c0, c1, t, p, idx, frac, f, num, den, q, ka, kb;
    lux_res_t r;
    c0 = bb;
    c1 = ir;
    t = (integ_ms != 0) ? integ_ms : 1;
    if (!gain_high) begin
      c0 = c0 << 4;
      c1 = c1 << 4;
    end
    r.lux = '0;
    r.sat = 1'b0;
    r.oor = 1'b1;
    if (c0 == 0 || 10 * c1 > 13 * c0) return r;
    r.oor = 1'b0;
    if (2 * c1 <= c0) begin
      p = ((c1 * 2 * SPAN) << 16) / c0;
      idx = p >> 16;
      frac = p & 64'hFFFF;
      if (idx >= SPAN) f = curve[SPAN];
      else f = curve[idx] + ((sub_floor(curve[idx+1], curve[idx]) * frac) >> 16);
      num = 402 * c0 * sub_floor(64'd3040 * 65536, 6200 * f);
      den = t * 1600000;
    end else begin
      if (100 * c1 <= 61 * c0) begin
        ka = 2240; kb = 3100;
      end else if (5 * c1 <= 4 * c0) begin
        ka = 1280; kb = 1530;
      end else begin
        ka = 146; kb = 112;
      end
      num = 402 * 4096 * sub_floor(ka * c0, kb * c1);
      den = t * 100000;
    end
    q = (num + den / 2) / den;
    if (q > 64'hFFFF_FFFF) begin
      r.lux = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      r.lux = q[31:0];
    end
    return r;
  endfunction

  initial begin
    longint unsigned x, x7, lo, hi, mid;
    fail_count = 0;
    outstanding = 0;
    gain_high = 1'b0;
    integ_ms = INTEG_RESET;
    for (int i = 0; i < CURVE_ENTRIES_DEF; i++) begin
      x = (longint'(i) << 29) / SPAN;
      x7 = pow_q30(x, 7);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow_q30(mid << 14, 5) <= x7) lo = mid;
        else hi = mid - 1;
      end
      curve[i] = lo[15:0];
    end
  end

  // All inputs change at the rising edge; evaluate the coming edge at the falling one.
  always @(negedge clk) begin
    lux_res_t e;
    if (rst) begin
      gain_high = 1'b0;
      integ_ms = INTEG_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HIGH_GAIN) gain_high = cfg_data[0];
        else integ_ms = cfg_data;
      end
      if (samples.valid && samples.ready)
        expected_lux.push_back(lux_predict(samples.broadband_count, samples.infrared_count));
      if (results.valid && results.ready) begin
        if (expected_lux.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: lux %h sat %b oor %b", results.lux_value,
                     results.saturated, results.out_of_range);
        end else begin
          e = expected_lux.pop_front();
          if (e.lux !== results.lux_value || e.sat !== results.saturated ||
              e.oor !== results.out_of_range) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected lux %h sat %b oor %b, got lux %h sat %b oor %b",
                       e.lux, e.sat, e.oor, results.lux_value, results.saturated,
                       results.out_of_range);
          end
        end
      end
    end
    outstanding = expected_lux.size();
  end

endmodule

### sim/tb_two_channel_lux_calculator.sv
// Testbench top: drives counts and configuration into the lux calculator and reports the verdict.
module tb_two_channel_lux_calculator;
  import tclc_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;
  logic calm;
  int stall_left;
  int fail_count;
  int outstanding;

  tclc_sample_if smp ();
  tclc_result_if res ();

  two_channel_lux_calculator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(smp), .results(res)
  );

  tclc_lux_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(smp), .results(res), .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      res.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic send_counts(input logic [15:0] bb, input logic [15:0] ir);
    logic took;
    if (!calm && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.broadband_count <= bb;
    smp.infrared_count <= ir;
    do begin
      @(negedge clk);
      took = smp.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    smp.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic send_random();
    logic [15:0] bb;
    logic [31:0] ir;
    int width;
    case ($urandom_range(0, 3))
      0: begin
        bb = 16'($urandom);
        ir = $urandom & 32'hFFFF;
      end
      3: begin
        width = $urandom_range(1, 5);
        bb = 16'($urandom & ((1 << width) - 1));
        ir = $urandom & ((1 << width) - 1);
      end
      default: begin
        width = $urandom_range(1, 16);
        bb = 16'($urandom & ((32'd1 << width) - 1));
        ir = (32'(bb) * $urandom_range(0, 1400)) / 1000;
        if (ir > 32'hFFFF) ir = 32'hFFFF;
      end
    endcase
    send_counts(bb, ir[15:0]);
  endtask

  initial begin
    logic [15:0] integ_set [7];
    logic gain_set [7];
    rst = 1'b1;
    calm = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HIGH_GAIN;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.broadband_count = '0;
    smp.infrared_count = '0;
    integ_set = '{16'd402, 16'd1, 16'd65535, 16'd402, 16'd1, 16'd65535, 16'd13};
    gain_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_counts(16'd0, 16'd0);
    send_counts(16'd0, 16'hFFFF);
    send_counts(16'hFFFF, 16'd0);
    send_counts(16'hFFFF, 16'hFFFF);
    send_counts(16'd1, 16'd0);
    send_counts(16'd2, 16'd1);
    send_counts(16'd200, 16'd101);
    send_counts(16'd100, 16'd61);
    send_counts(16'd100, 16'd62);
    send_counts(16'd5, 16'd4);
    send_counts(16'd500, 16'd401);
    send_counts(16'd10, 16'd13);
    send_counts(16'd10, 16'd14);
    send_counts(16'hFFFF, 16'h7FFF);
    send_counts(16'hFFFF, 16'd1);
    send_counts(16'h5555, 16'h2AAA);
    send_counts(16'hAAAA, 16'h5555);
    send_counts(16'd3, 16'd1);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(CFG_HIGH_GAIN, {15'd0, gain_set[ph]});
      write_reg(CFG_INTEG_MS, integ_set[ph]);
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 218; n++) send_random();
    end
    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
design/tclc_pkg.sv
design/tclc_ifs.sv
design/tclc_div.sv
design/two_channel_lux_calculator.sv
sim/tclc_lux_checker.sv
sim/tb_two_channel_lux_calculator.sv
